/* hdl/bounded_priority_job_scheduler_unit_macros.svh */
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Immediate-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_JOB_SCHEDULER_UNIT_MACROS_SVH
`define BOUNDED_PRIORITY_JOB_SCHEDULER_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define BPJS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// check cons in the cycle after ante
`define BPJS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

/* hdl/bpjs_pkg.sv */
// ----------------------------------------------------------------------------
// bpjs_pkg
// Word types and codes shared by the job scheduler modules.
// ----------------------------------------------------------------------------
package bpjs_pkg;

    localparam logic [2:0] CMD_SCHEDULE   = 3'd0;
    localparam logic [2:0] CMD_TAKE       = 3'd1;
    localparam logic [2:0] CMD_COMPLETE   = 3'd2;
    localparam logic [2:0] CMD_SUPERSEDE  = 3'd3;
    localparam logic [2:0] CMD_CANCEL_PRI = 3'd4;
    localparam logic [2:0] CMD_CANCEL_ALL = 3'd5;
    localparam logic [2:0] CMD_MAINT      = 3'd6;
    localparam logic [2:0] CMD_CLOSE      = 3'd7;

    localparam logic [3:0] K_ACCEPTED  = 4'd0;
    localparam logic [3:0] K_REJECTED  = 4'd1;
    localparam logic [3:0] K_JOB       = 4'd2;
    localparam logic [3:0] K_MAINT     = 4'd3;
    localparam logic [3:0] K_CLOSED    = 4'd4;
    localparam logic [3:0] K_PEND_CANC = 4'd5;
    localparam logic [3:0] K_ACT_CANC  = 4'd6;
    localparam logic [3:0] K_DONE      = 4'd7;
    localparam logic [3:0] K_NEW_GEN   = 4'd8;

    localparam logic [1:0] CFG_MAX_PENDING = 2'd0;
    localparam logic [1:0] CFG_HOVER_RANK  = 2'd1;
    localparam logic [1:0] CFG_INTER_MAX   = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  job_priority;
        logic [31:0] job_key;
        logic [31:0] job_generation;
        logic [3:0]  worker_index;
        logic        already_cancelled;
        logic        stop_request;
        logic [31:0] seen_maint_gen;
    } t_in;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] out_key;
        logic [31:0] out_generation;
        logic [2:0]  out_priority;
        logic [31:0] out_sequence;
        logic [3:0]  out_slot;
        logic [31:0] maint_gen;
        logic [4:0]  pending_now;
        logic        is_closed;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] gen;
        logic [2:0]  prio;
        logic [31:0] seq;
    } t_pend;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] key;
        logic [31:0] gen;
        logic [2:0]  prio;
        logic [31:0] seq;
        logic [3:0]  slot;
    } t_rec;

endpackage

/* hdl/bounded_priority_job_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// bounded_priority_job_scheduler_unit
// Bounded priority job scheduler with pending table and worker slots.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. The sequencer
// works through the command in passes over the pending table memory, in
// which each pending entry is read and then evaluated, and in slot scans
// that visit each worker slot in turn; a schedule runs up to four table
// passes and one slot scan, a take two table passes. All results of a
// command are then played out on o_res, one per cycle on consecutive cycles
// marked by o_strobe, the final one with last set. The receiver cannot
// stall, so results must be taken as shown.
// Configuration writes are always ready and take effect at once, also
// during a command.
// ----------------------------------------------------------------------------
`include "bounded_priority_job_scheduler_unit_macros.svh"

module bounded_priority_job_scheduler_unit #(
    parameter int PENDING_DEPTH = 16,
    parameter int WORKER_SLOTS  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  bpjs_pkg::t_in     i_in,
    output logic              o_strobe,
    output bpjs_pkg::t_out    o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [4:0]        i_cfg_data
);

    localparam int AW   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW   = $clog2(PENDING_DEPTH + 1);
    localparam int RDEP = PENDING_DEPTH + WORKER_SLOTS + 1;
    localparam int RAW  = $clog2(RDEP);
    localparam int RCW  = $clog2(RDEP + 1);
    localparam int SIW  = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_EV   = 6'b000100,
        S_SLOT = 6'b001000,
        S_NEXT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        PM_HOVER, PM_KEY, PM_PRIO, PM_ALL, PM_IDX, PM_WORST, PM_BEST
    } t_pmode;

    typedef enum logic [1:0] {SM_SUP, SM_EQ, SM_BUSY} t_smode;

    t_state r_state, n_state;
    t_pmode r_pmode, n_pmode;
    t_smode r_smode, n_smode;
    bpjs_pkg::t_in   r_item;
    bpjs_pkg::t_pend r_best, n_best;
    logic [2:0]      r_ph, n_ph;
    logic [CW-1:0]   r_cnt, n_cnt, r_rd, n_rd, r_wr, n_wr, r_tgt, n_tgt;
    logic            r_rej, n_rej, r_iemit, n_iemit;
    logic [SIW-1:0]  r_si, n_si;
    logic [RCW-1:0]  r_nres, n_nres, r_oi, n_oi;
    logic [31:0]     r_seq, n_seq, r_maint, n_maint;
    logic            r_closed, n_closed;
    logic            r_ov, n_ov, r_olast, n_olast;
    logic [4:0]      r_maxp;
    logic [2:0]      r_hover, r_imr;
    logic            r_sbusy [WORKER_SLOTS];
    logic [31:0]     r_sgen  [WORKER_SLOTS];
    logic [2:0]      r_sprio [WORKER_SLOTS];

    logic            s_wr, s_clr;
    logic [SIW-1:0]  s_widx;

    logic            pm_we;
    logic [AW-1:0]   pm_waddr;
    bpjs_pkg::t_pend pm_wdata, pm_rdata;
    logic            em_v;
    bpjs_pkg::t_rec  em, rb_rdata;
    logic [9:0]      lim;
    logic            widx_ok, rm, better;

    bpjs_ram #(.DEPTH(PENDING_DEPTH), .WIDTH($bits(bpjs_pkg::t_pend)), .AW(AW)) u_pend (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (pm_rdata)
    );

    bpjs_ram #(.DEPTH(RDEP), .WIDTH($bits(bpjs_pkg::t_rec)), .AW(RAW)) u_res (
        .i_clk   (i_clk),
        .i_we    (em_v && (r_nres < RCW'(RDEP))),
        .i_waddr (r_nres[RAW-1:0]),
        .i_wdata (em),
        .i_raddr (r_oi[RAW-1:0]),
        .o_rdata (rb_rdata)
    );

    assign widx_ok = ({1'b0, r_item.worker_index} < 5'(WORKER_SLOTS));
    assign s_widx  = r_item.worker_index[SIW-1:0];

    always_comb begin
        if (r_maxp == 5'd0) begin
            lim = 10'd1;
        end else begin
            lim = {5'd0, r_maxp};
        end
        if (lim > 10'(PENDING_DEPTH)) begin
            lim = 10'(PENDING_DEPTH);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pmode  = r_pmode;
        n_smode  = r_smode;
        n_best   = r_best;
        n_ph     = r_ph;
        n_cnt    = r_cnt;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_tgt    = r_tgt;
        n_rej    = r_rej;
        n_iemit  = r_iemit;
        n_si     = r_si;
        n_nres   = r_nres;
        n_oi     = r_oi;
        n_seq    = r_seq;
        n_maint  = r_maint;
        n_closed = r_closed;
        n_ov     = 1'b0;
        n_olast  = 1'b0;
        s_wr     = 1'b0;
        s_clr    = 1'b0;
        pm_we    = 1'b0;
        pm_waddr = r_wr[AW-1:0];
        pm_wdata = pm_rdata;
        em_v     = 1'b0;
        em       = '0;
        rm       = 1'b0;
        better   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_NEXT;
                    n_ph    = 3'd0;
                    n_nres  = '0;
                end
            end
            S_RD: begin
                if (r_rd == r_cnt) begin
                    if (r_pmode != PM_WORST && r_pmode != PM_BEST) begin
                        n_cnt = r_wr;
                    end
                    n_state = S_NEXT;
                end else begin
                    n_state = S_EV;
                end
            end
            S_EV: begin
                n_rd    = r_rd + CW'(1);
                n_state = S_RD;
                unique case (r_pmode)
                    PM_HOVER: rm = (pm_rdata.prio == r_hover);
                    PM_KEY: begin
                        if (!r_rej && pm_rdata.key == r_item.job_key) begin
                            if (r_item.job_priority > pm_rdata.prio) begin
                                n_rej = 1'b1;
                            end else begin
                                rm = 1'b1;
                            end
                        end
                    end
                    PM_PRIO:  rm = (pm_rdata.prio == r_item.job_priority);
                    PM_ALL:   rm = 1'b1;
                    PM_IDX:   rm = (r_rd == r_tgt);
                    PM_WORST: better = (r_rd == '0) || (pm_rdata.prio > r_best.prio) ||
                                       (pm_rdata.prio == r_best.prio &&
                                        pm_rdata.seq < r_best.seq);
                    PM_BEST:  better = (r_rd == '0) || (pm_rdata.prio < r_best.prio) ||
                                       (pm_rdata.prio == r_best.prio &&
                                        pm_rdata.seq > r_best.seq);
                    default:  rm = 1'b0;
                endcase
                if (r_pmode == PM_WORST || r_pmode == PM_BEST) begin
                    if (better) begin
                        n_best = pm_rdata;
                        n_tgt  = r_rd;
                    end
                end else if (rm) begin
                    if (r_pmode != PM_IDX || r_iemit) begin
                        em_v = 1'b1;
                        em   = '{bpjs_pkg::K_PEND_CANC, pm_rdata.key, pm_rdata.gen,
                                 pm_rdata.prio, pm_rdata.seq, 4'd0};
                    end
                end else begin
                    pm_we = 1'b1;
                    n_wr  = r_wr + CW'(1);
                end
            end
            S_SLOT: begin
                case (r_smode)
                    SM_SUP:  rm = r_sbusy[r_si] && (r_sprio[r_si] >= r_item.job_priority);
                    SM_EQ:   rm = r_sbusy[r_si] && (r_sprio[r_si] == r_item.job_priority);
                    default: rm = r_sbusy[r_si];
                endcase
                if (rm) begin
                    em_v = 1'b1;
                    em   = '{bpjs_pkg::K_ACT_CANC, 32'd0, r_sgen[r_si], r_sprio[r_si],
                             32'd0, 4'(r_si)};
                end
                if (r_si == SIW'(WORKER_SLOTS - 1)) begin
                    n_state = S_NEXT;
                end else begin
                    n_si = r_si + SIW'(1);
                end
            end
            S_NEXT: begin
                n_ph = r_ph + 3'd1;
                unique case (r_item.command)
                    bpjs_pkg::CMD_SCHEDULE: begin
                        case (r_ph)
                            3'd0: begin
                                if (r_item.already_cancelled || r_closed) begin
                                    em_v = 1'b1;
                                    em   = '{bpjs_pkg::K_REJECTED, r_item.job_key,
                                             r_item.job_generation, r_item.job_priority,
                                             32'd0, 4'd0};
                                    n_state = S_OUT;
                                end else begin
                                    n_seq = (r_seq == 32'hFFFF_FFFF) ? 32'd1 : r_seq + 32'd1;
                                    if (r_item.job_priority == r_hover) begin
                                        n_state = S_RD;
                                        n_pmode = PM_HOVER;
                                    end
                                end
                            end
                            3'd1: begin
                                if (r_item.job_priority <= r_imr) begin
                                    n_state = S_SLOT;
                                    n_smode = SM_SUP;
                                end
                            end
                            3'd2: begin
                                n_state = S_RD;
                                n_pmode = PM_KEY;
                            end
                            3'd3: begin
                                if (r_rej) begin
                                    em_v = 1'b1;
                                    em   = '{bpjs_pkg::K_REJECTED, r_item.job_key,
                                             r_item.job_generation, r_item.job_priority,
                                             32'd0, 4'd0};
                                    n_state = S_OUT;
                                end else if ((10'(r_cnt) >= lim) && (r_cnt != '0)) begin
                                    n_state = S_RD;
                                    n_pmode = PM_WORST;
                                end else begin
                                    n_ph = 3'd5;
                                end
                            end
                            3'd4: begin
                                if (r_item.job_priority > r_best.prio) begin
                                    em_v = 1'b1;
                                    em   = '{bpjs_pkg::K_REJECTED, r_item.job_key,
                                             r_item.job_generation, r_item.job_priority,
                                             32'd0, 4'd0};
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_RD;
                                    n_pmode = PM_IDX;
                                    n_iemit = 1'b1;
                                end
                            end
                            default: begin
                                em_v    = 1'b1;
                                n_state = S_OUT;
                                if (r_cnt == CW'(PENDING_DEPTH)) begin
                                    em = '{bpjs_pkg::K_REJECTED, r_item.job_key,
                                           r_item.job_generation, r_item.job_priority,
                                           32'd0, 4'd0};
                                end else begin
                                    em = '{bpjs_pkg::K_ACCEPTED, r_item.job_key,
                                           r_item.job_generation, r_item.job_priority,
                                           r_seq, 4'd0};
                                    pm_we    = 1'b1;
                                    pm_waddr = r_cnt[AW-1:0];
                                    pm_wdata = '{r_item.job_key, r_item.job_generation,
                                                 r_item.job_priority, r_seq};
                                    n_cnt    = r_cnt + CW'(1);
                                end
                            end
                        endcase
                    end
                    bpjs_pkg::CMD_TAKE: begin
                        case (r_ph)
                            3'd0: begin
                                if (r_closed || r_item.stop_request) begin
                                    em_v    = 1'b1;
                                    em.kind = bpjs_pkg::K_CLOSED;
                                    n_state = S_OUT;
                                end else if (r_maint != r_item.seen_maint_gen ||
                                             r_cnt == '0) begin
                                    em_v    = 1'b1;
                                    em.kind = bpjs_pkg::K_MAINT;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_RD;
                                    n_pmode = PM_BEST;
                                end
                            end
                            3'd1: begin
                                s_wr    = widx_ok;
                                em_v    = 1'b1;
                                em      = '{bpjs_pkg::K_JOB, r_best.key, r_best.gen,
                                            r_best.prio, r_best.seq, 4'd0};
                                n_state = S_RD;
                                n_pmode = PM_IDX;
                                n_iemit = 1'b0;
                            end
                            default: n_state = S_OUT;
                        endcase
                    end
                    bpjs_pkg::CMD_COMPLETE: begin
                        s_clr   = widx_ok && r_sbusy[s_widx] &&
                                  (r_sgen[s_widx] == r_item.job_generation);
                        em_v    = 1'b1;
                        em.kind = bpjs_pkg::K_DONE;
                        n_state = S_OUT;
                    end
                    bpjs_pkg::CMD_SUPERSEDE: begin
                        case (r_ph)
                            3'd0: begin
                                if (r_item.job_priority == r_hover) begin
                                    n_state = S_RD;
                                    n_pmode = PM_HOVER;
                                end
                            end
                            3'd1: begin
                                if (r_item.job_priority <= r_imr) begin
                                    n_state = S_SLOT;
                                    n_smode = SM_SUP;
                                end
                            end
                            default: begin
                                em_v    = 1'b1;
                                em.kind = bpjs_pkg::K_DONE;
                                n_state = S_OUT;
                            end
                        endcase
                    end
                    bpjs_pkg::CMD_CANCEL_PRI: begin
                        case (r_ph)
                            3'd0: begin
                                n_state = S_RD;
                                n_pmode = PM_PRIO;
                            end
                            3'd1: begin
                                n_state = S_SLOT;
                                n_smode = SM_EQ;
                            end
                            default: begin
                                em_v    = 1'b1;
                                em.kind = bpjs_pkg::K_DONE;
                                n_state = S_OUT;
                            end
                        endcase
                    end
                    default: begin
                        case (r_ph)
                            3'd0: begin
                                if (r_item.command == bpjs_pkg::CMD_CLOSE && r_closed) begin
                                    em_v    = 1'b1;
                                    em.kind = bpjs_pkg::K_DONE;
                                    n_state = S_OUT;
                                end else begin
                                    if (r_item.command == bpjs_pkg::CMD_CLOSE) begin
                                        n_closed = 1'b1;
                                    end
                                    n_state = S_RD;
                                    n_pmode = PM_ALL;
                                end
                            end
                            3'd1: begin
                                n_state = S_SLOT;
                                n_smode = SM_BUSY;
                            end
                            default: begin
                                em_v    = 1'b1;
                                n_state = S_OUT;
                                if (r_item.command == bpjs_pkg::CMD_MAINT) begin
                                    em.kind = bpjs_pkg::K_NEW_GEN;
                                    n_maint = (r_maint == 32'hFFFF_FFFF) ? 32'd1 :
                                              r_maint + 32'd1;
                                end else begin
                                    em.kind = bpjs_pkg::K_DONE;
                                end
                            end
                        endcase
                    end
                endcase
                if (n_state == S_RD) begin
                    n_rd  = '0;
                    n_wr  = '0;
                    n_rej = 1'b0;
                end
                if (n_state == S_SLOT) begin
                    n_si = '0;
                end
                if (n_state == S_OUT) begin
                    n_oi = '0;
                end
            end
            S_OUT: begin
                n_ov    = 1'b1;
                n_olast = (r_oi == r_nres - RCW'(1));
                if (n_olast) begin
                    n_state = S_IDLE;
                end else begin
                    n_oi = r_oi + RCW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (em_v && (r_nres < RCW'(RDEP))) begin
            n_nres = r_nres + RCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_seq    <= '0;
            r_maint  <= '0;
            r_closed <= 1'b0;
            r_ov     <= 1'b0;
            r_olast  <= 1'b0;
            r_nres   <= '0;
            r_maxp   <= 5'd16;
            r_hover  <= 3'd0;
            r_imr    <= 3'd1;
            for (int s = 0; s < WORKER_SLOTS; s++) begin
                r_sbusy[s] <= 1'b0;
                r_sgen[s]  <= '0;
                r_sprio[s] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_seq    <= n_seq;
            r_maint  <= n_maint;
            r_closed <= n_closed;
            r_ov     <= n_ov;
            r_olast  <= n_olast;
            r_nres   <= n_nres;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bpjs_pkg::CFG_MAX_PENDING: r_maxp  <= i_cfg_data;
                    bpjs_pkg::CFG_HOVER_RANK:  r_hover <= i_cfg_data[2:0];
                    bpjs_pkg::CFG_INTER_MAX:   r_imr   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_wr) begin
                r_sbusy[s_widx] <= 1'b1;
                r_sgen[s_widx]  <= r_best.gen;
                r_sprio[s_widx] <= r_best.prio;
            end
            if (s_clr) begin
                r_sbusy[s_widx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_item <= i_in;
        end
        r_pmode <= n_pmode;
        r_smode <= n_smode;
        r_best  <= n_best;
        r_ph    <= n_ph;
        r_rd    <= n_rd;
        r_wr    <= n_wr;
        r_tgt   <= n_tgt;
        r_rej   <= n_rej;
        r_iemit <= n_iemit;
        r_si    <= n_si;
        r_oi    <= n_oi;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_ov;

    always_comb begin
        o_res.kind           = rb_rdata.kind;
        o_res.out_key        = rb_rdata.key;
        o_res.out_generation = rb_rdata.gen;
        o_res.out_priority   = rb_rdata.prio;
        o_res.out_sequence   = rb_rdata.seq;
        o_res.out_slot       = rb_rdata.slot;
        o_res.maint_gen      = r_maint;
        o_res.pending_now    = 5'(r_cnt);
        o_res.is_closed      = r_closed;
        o_res.last           = r_olast;
    end

    `BPJS_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(PENDING_DEPTH))
    `BPJS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `BPJS_ASSERT_NEXT(a_burst_contig, i_clk, i_rst_n, o_strobe && !o_res.last, o_strobe)
    `BPJS_ASSERT_NOW(a_burst_busy, i_clk, i_rst_n, o_strobe && !o_res.last, r_state == S_OUT)

endmodule

/* hdl/bpjs_ram.sv */
// ----------------------------------------------------------------------------
// bpjs_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module bpjs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/tb_bounded_priority_job_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// tb_bounded_priority_job_scheduler_unit
// Self-checking bench for the job scheduler: a scoreboard predicts every
// result word of each accepted command and checks the strobed results in
// order, across several register settings, directed and random commands.
// ----------------------------------------------------------------------------
module tb_bounded_priority_job_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int SLOTS = 4;

    class sched_scoreboard;
        logic [31:0] pkey[DEPTH];
        logic [31:0] pgen[DEPTH];
        logic [31:0] pseq[DEPTH];
        logic [2:0]  pprio[DEPTH];
        int          pcnt;
        bit          sbusy[SLOTS];
        logic [31:0] sgen[SLOTS];
        logic [2:0]  sprio[SLOTS];
        logic [31:0] seqc;
        logic [31:0] maint;
        bit          closed;
        logic [4:0]  max_pend;
        logic [2:0]  hover;
        logic [2:0]  inter_max;
        bpjs_pkg::t_rec evs[$];
        bpjs_pkg::t_out expq[$];
        int          errs;
        int          checked;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                pkey[i] = '0; pgen[i] = '0; pseq[i] = '0; pprio[i] = '0;
            end
            for (int s = 0; s < SLOTS; s++) begin
                sbusy[s] = 0; sgen[s] = '0; sprio[s] = '0;
            end
            pcnt = 0; seqc = '0; maint = '0; closed = 0;
            max_pend = 5'd16; hover = 3'd0; inter_max = 3'd1;
            errs = 0; checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [4:0] d);
            case (idx)
                bpjs_pkg::CFG_MAX_PENDING: max_pend = d;
                bpjs_pkg::CFG_HOVER_RANK:  hover = d[2:0];
                bpjs_pkg::CFG_INTER_MAX:   inter_max = d[2:0];
                default: ;
            endcase
        endfunction

        function void push(logic [3:0] k, logic [31:0] key, logic [31:0] gen,
                           logic [2:0] prio, logic [31:0] seq, logic [3:0] slot);
            bpjs_pkg::t_rec r;
            r.kind = k; r.key = key; r.gen = gen; r.prio = prio; r.seq = seq;
            r.slot = slot;
            evs.insert(evs.size(), r);
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? 32'd1 : v + 32'd1;
        endfunction

        function void drop_at(int i, bit report);
            if (report) push(bpjs_pkg::K_PEND_CANC, pkey[i], pgen[i], pprio[i], pseq[i], '0);
            for (int j = i; j + 1 < pcnt; j++) begin
                pkey[j] = pkey[j+1]; pgen[j] = pgen[j+1];
                pprio[j] = pprio[j+1]; pseq[j] = pseq[j+1];
            end
            pcnt--;
        endfunction

        function void supersede(logic [2:0] p);
            int i;
            i = 0;
            if (p == hover) begin
                while (i < pcnt) begin
                    if (pprio[i] == hover) drop_at(i, 1);
                    else i++;
                end
            end
            if (p > inter_max) return;
            for (int s = 0; s < SLOTS; s++)
                if (sbusy[s] && sprio[s] >= p)
                    push(bpjs_pkg::K_ACT_CANC, '0, sgen[s], sprio[s], '0, s[3:0]);
        endfunction

        function void cancel_all();
            while (pcnt > 0) drop_at(0, 1);
            for (int s = 0; s < SLOTS; s++)
                if (sbusy[s]) push(bpjs_pkg::K_ACT_CANC, '0, sgen[s], sprio[s], '0, s[3:0]);
        endfunction

        function void schedule(bpjs_pkg::t_in it);
            int i;
            int w;
            int lim;
            if (it.already_cancelled || closed) begin
                push(bpjs_pkg::K_REJECTED, it.job_key, it.job_generation, it.job_priority,
                     '0, '0);
                return;
            end
            seqc = bump(seqc);
            supersede(it.job_priority);
            i = 0;
            while (i < pcnt) begin
                if (pkey[i] != it.job_key) begin
                    i++;
                end else if (it.job_priority > pprio[i]) begin
                    push(bpjs_pkg::K_REJECTED, it.job_key, it.job_generation,
                         it.job_priority, '0, '0);
                    return;
                end else begin
                    drop_at(i, 1);
                end
            end
            lim = (max_pend == 0) ? 1 : int'(max_pend);
            if (lim > DEPTH) lim = DEPTH;
            if (pcnt >= lim && pcnt > 0) begin
                w = 0;
                for (int j = 1; j < pcnt; j++)
                    if (pprio[j] > pprio[w] || (pprio[j] == pprio[w] && pseq[j] < pseq[w]))
                        w = j;
                if (it.job_priority > pprio[w]) begin
                    push(bpjs_pkg::K_REJECTED, it.job_key, it.job_generation,
                         it.job_priority, '0, '0);
                    return;
                end
                drop_at(w, 1);
            end
            if (pcnt >= DEPTH) begin
                push(bpjs_pkg::K_REJECTED, it.job_key, it.job_generation, it.job_priority,
                     '0, '0);
                return;
            end
            pkey[pcnt] = it.job_key; pgen[pcnt] = it.job_generation;
            pprio[pcnt] = it.job_priority; pseq[pcnt] = seqc;
            pcnt++;
            push(bpjs_pkg::K_ACCEPTED, it.job_key, it.job_generation, it.job_priority,
                 seqc, '0);
        endfunction

        function void take(bpjs_pkg::t_in it);
            int b;
            if (closed || it.stop_request) begin
                push(bpjs_pkg::K_CLOSED, '0, '0, '0, '0, '0);
                return;
            end
            if (maint != it.seen_maint_gen || pcnt == 0) begin
                push(bpjs_pkg::K_MAINT, '0, '0, '0, '0, '0);
                return;
            end
            b = 0;
            for (int j = 1; j < pcnt; j++)
                if (pprio[j] < pprio[b] || (pprio[j] == pprio[b] && pseq[j] > pseq[b]))
                    b = j;
            if (it.worker_index < SLOTS) begin
                sbusy[it.worker_index] = 1;
                sgen[it.worker_index] = pgen[b];
                sprio[it.worker_index] = pprio[b];
            end
            push(bpjs_pkg::K_JOB, pkey[b], pgen[b], pprio[b], pseq[b], '0);
            drop_at(b, 0);
        endfunction

        function void note(bpjs_pkg::t_in it);
            int i;
            bpjs_pkg::t_out o;
            evs.delete();
            case (it.command)
                bpjs_pkg::CMD_SCHEDULE: schedule(it);
                bpjs_pkg::CMD_TAKE:     take(it);
                bpjs_pkg::CMD_COMPLETE: begin
                    if (it.worker_index < SLOTS && sbusy[it.worker_index] &&
                        sgen[it.worker_index] == it.job_generation)
                        sbusy[it.worker_index] = 0;
                    push(bpjs_pkg::K_DONE, '0, '0, '0, '0, '0);
                end
                bpjs_pkg::CMD_SUPERSEDE: begin
                    supersede(it.job_priority);
                    push(bpjs_pkg::K_DONE, '0, '0, '0, '0, '0);
                end
                bpjs_pkg::CMD_CANCEL_PRI: begin
                    i = 0;
                    while (i < pcnt) begin
                        if (pprio[i] == it.job_priority) drop_at(i, 1);
                        else i++;
                    end
                    for (int s = 0; s < SLOTS; s++)
                        if (sbusy[s] && sprio[s] == it.job_priority)
                            push(bpjs_pkg::K_ACT_CANC, '0, sgen[s], sprio[s], '0, s[3:0]);
                    push(bpjs_pkg::K_DONE, '0, '0, '0, '0, '0);
                end
                bpjs_pkg::CMD_CANCEL_ALL: begin
                    cancel_all();
                    push(bpjs_pkg::K_DONE, '0, '0, '0, '0, '0);
                end
                bpjs_pkg::CMD_MAINT: begin
                    cancel_all();
                    maint = bump(maint);
                    push(bpjs_pkg::K_NEW_GEN, '0, '0, '0, '0, '0);
                end
                default: begin
                    if (!closed) begin
                        closed = 1;
                        cancel_all();
                    end
                    push(bpjs_pkg::K_DONE, '0, '0, '0, '0, '0);
                end
            endcase
            for (int k = 0; k < evs.size(); k++) begin
                o.kind = evs[k].kind; o.out_key = evs[k].key;
                o.out_generation = evs[k].gen; o.out_priority = evs[k].prio;
                o.out_sequence = evs[k].seq; o.out_slot = evs[k].slot;
                o.maint_gen = maint; o.pending_now = pcnt[4:0];
                o.is_closed = closed; o.last = (k == evs.size() - 1);
                expq.insert(expq.size(), o);
            end
        endfunction

        function void check(bpjs_pkg::t_out got);
            bpjs_pkg::t_out e;
            if (expq.size() == 0) begin
                errs++;
                if (errs <= 10) $display("ERROR: unexpected result word kind=%0d", got.kind);
                return;
            end
            e = expq.pop_front();
            checked++;
            if (got !== e) begin
                errs++;
                if (errs <= 10) begin
                    $display("ERROR: result %0d mismatch", checked);
                    $display("  exp kind=%0d key=%h gen=%h pri=%0d seq=%h slot=%0d",
                             e.kind, e.out_key, e.out_generation, e.out_priority,
                             e.out_sequence, e.out_slot);
                    $display("      mg=%h pn=%0d c=%0d l=%0d",
                             e.maint_gen, e.pending_now, e.is_closed, e.last);
                    $display("  got kind=%0d key=%h gen=%h pri=%0d seq=%h slot=%0d",
                             got.kind, got.out_key, got.out_generation, got.out_priority,
                             got.out_sequence, got.out_slot);
                    $display("      mg=%h pn=%0d c=%0d l=%0d",
                             got.maint_gen, got.pending_now, got.is_closed, got.last);
                end
            end
        endfunction
    endclass

    logic           i_clk = 0;
    logic           i_rst_n = 0;
    logic           i_start = 0;
    logic           o_busy;
    bpjs_pkg::t_in  i_in = '0;
    logic           o_strobe;
    bpjs_pkg::t_out o_res;
    logic           i_cfg_valid = 0;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index = '0;
    logic [4:0]     i_cfg_data = '0;

    sched_scoreboard sb = new();
    int  n_sent = 0;
    bit  idle_on = 1;

    bounded_priority_job_scheduler_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_in(i_in), .o_strobe(o_strobe), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check(o_res);
    end

    task automatic send_cmd(bpjs_pkg::t_in it);
        int gap;
        i_in    <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note(it);
        n_sent++;
        gap = (idle_on && $urandom_range(0, 99) < 29) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.expq.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bpjs_pkg::t_in mk(logic [2:0] cmd, logic [2:0] p, logic [31:0] key,
                                         logic [31:0] gen, logic [3:0] w);
        bpjs_pkg::t_in it;
        it = '0;
        it.command = cmd; it.job_priority = p; it.job_key = key;
        it.job_generation = gen; it.worker_index = w;
        it.seen_maint_gen = sb.maint;
        return it;
    endfunction

    function automatic bpjs_pkg::t_in rand_item();
        bpjs_pkg::t_in it;
        int  r;
        it = '0;
        r = $urandom_range(0, 99);
        if (r < 45)      it.command = bpjs_pkg::CMD_SCHEDULE;
        else if (r < 72) it.command = bpjs_pkg::CMD_TAKE;
        else if (r < 84) it.command = bpjs_pkg::CMD_COMPLETE;
        else if (r < 89) it.command = bpjs_pkg::CMD_SUPERSEDE;
        else if (r < 94) it.command = bpjs_pkg::CMD_CANCEL_PRI;
        else if (r < 97) it.command = bpjs_pkg::CMD_CANCEL_ALL;
        else             it.command = bpjs_pkg::CMD_MAINT;
        it.job_priority = $urandom_range(0, 7);
        it.job_key = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 7);
        r = $urandom_range(0, 9);
        if (it.command == bpjs_pkg::CMD_COMPLETE && r < 7)
            it.job_generation = sb.sgen[$urandom_range(0, SLOTS - 1)];
        else if (r == 9)
            it.job_generation = $urandom();
        else
            it.job_generation = $urandom_range(0, 3);
        it.worker_index = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, SLOTS - 1);
        it.already_cancelled = ($urandom_range(0, 9) == 0);
        it.stop_request = ($urandom_range(0, 9) == 0);
        it.seen_maint_gen = ($urandom_range(0, 7) == 0) ? $urandom() : sb.maint;
        return it;
    endfunction

    initial begin
        bpjs_pkg::t_in it;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd3, 32'd1, 32'd5, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd5, 32'd1, 32'd6, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd2, 32'd1, 32'd7, 4'd0));
        it = mk(bpjs_pkg::CMD_SCHEDULE, 3'd4, 32'd2, 32'd8, 4'd0);
        it.already_cancelled = 1;
        send_cmd(it);
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd0, 32'd0, 32'd0, 4'd0));
        it = mk(bpjs_pkg::CMD_TAKE, 3'd0, 32'd0, 32'd0, 4'd1);
        it.seen_maint_gen = 32'hFFFF_FFFF;
        send_cmd(it);
        it = mk(bpjs_pkg::CMD_TAKE, 3'd0, 32'd0, 32'd0, 4'd1);
        it.stop_request = 1;
        send_cmd(it);
        send_cmd(mk(bpjs_pkg::CMD_TAKE, 3'd0, 32'd0, 32'd0, 4'd15));
        send_cmd(mk(bpjs_pkg::CMD_TAKE, 3'd0, 32'd0, 32'd0, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_TAKE, 3'd0, 32'd0, 32'd0, 4'd3));
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd1, 32'd3, 32'd9, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_COMPLETE, 3'd0, 32'd0, 32'd99, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_COMPLETE, 3'd0, 32'd0, 32'd7, 4'd3));
        send_cmd(mk(bpjs_pkg::CMD_COMPLETE, 3'd0, 32'd0, 32'd7, 4'd15));
        send_cmd(mk(bpjs_pkg::CMD_SUPERSEDE, 3'd0, 32'd0, 32'd0, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_CANCEL_PRI, 3'd7, 32'd0, 32'd0, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_CANCEL_ALL, 3'd0, 32'd0, 32'd0, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_TAKE, 3'd0, 32'd0, 32'd0, 4'd2));
        send_cmd(mk(bpjs_pkg::CMD_MAINT, 3'd0, 32'd0, 32'd0, 4'd0));
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_cfg(bpjs_pkg::CFG_MAX_PENDING, 5'd2);
                         write_cfg(bpjs_pkg::CFG_HOVER_RANK, 5'd7);
                         write_cfg(bpjs_pkg::CFG_INTER_MAX, 5'd0); end
                1: begin write_cfg(bpjs_pkg::CFG_MAX_PENDING, 5'd0);
                         write_cfg(bpjs_pkg::CFG_HOVER_RANK, 5'd3);
                         write_cfg(bpjs_pkg::CFG_INTER_MAX, 5'd7); end
                2: begin write_cfg(bpjs_pkg::CFG_MAX_PENDING, 5'd31);
                         write_cfg(bpjs_pkg::CFG_HOVER_RANK, 5'd0);
                         write_cfg(bpjs_pkg::CFG_INTER_MAX, 5'd1); end
                3: begin write_cfg(bpjs_pkg::CFG_MAX_PENDING, 5'd5);
                         write_cfg(bpjs_pkg::CFG_HOVER_RANK, 5'd6);
                         write_cfg(bpjs_pkg::CFG_INTER_MAX, 5'd3); end
                default: begin write_cfg(bpjs_pkg::CFG_MAX_PENDING, 5'd16);
                         write_cfg(bpjs_pkg::CFG_HOVER_RANK, 5'd2);
                         write_cfg(bpjs_pkg::CFG_INTER_MAX, 5'd5); end
            endcase
            idle_on = (ph != 2);
            repeat (60) send_cmd(rand_item());
            drain();
        end

        // close and what follows it
        idle_on = 1;
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd4, 32'd11, 32'd1, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_CLOSE, 3'd0, 32'd0, 32'd0, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_CLOSE, 3'd0, 32'd0, 32'd0, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_SCHEDULE, 3'd0, 32'd12, 32'd2, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_TAKE, 3'd0, 32'd0, 32'd0, 4'd0));
        send_cmd(mk(bpjs_pkg::CMD_MAINT, 3'd0, 32'd0, 32'd0, 4'd0));
        drain();
        repeat (50) @(posedge i_clk);

        $display("Sent %0d commands over six register settings, checked %0d result words.",
                 n_sent, sb.checked);
        if (sb.errs == 0 && sb.expq.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errs, sb.expq.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for scheduler");
        $display("Test completed with failures");
        $finish;
    end
endmodule
